// ===== design/bpl_pkg.sv =====
// Shared types and constants for the bounded positional list.
// Used by bpl_store and bounded_positional_list; depends on nothing else.
`default_nettype none

package bpl_pkg;

    localparam int OP_W      = 3;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_EXT_FIRST = 3'd3,
        OP_EXT_LAST  = 3'd4,
        OP_EXT_AT    = 3'd5,
        OP_READ_AT   = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // shift control for the entry array
    typedef struct packed {
        logic ins;
        logic ext;
    } store_ctl_t;

endpackage

`default_nettype wire

// ===== design/bpl_store.sv =====
// Entry array of the positional list: parallel shift on insert and extract.
// Depends on bpl_pkg for the shift control struct.
`default_nettype none

module bpl_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire bpl_pkg::store_ctl_t        ctl,
    input  wire logic [$clog2(DEPTH)-1:0]   idx,
    input  wire logic [DATA_WIDTH-1:0]      wr_word,
    output logic      [DATA_WIDTH-1:0]      rd_word
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DATA_WIDTH-1:0] entry_reg [DEPTH];
    logic [DATA_WIDTH-1:0] from_prev [DEPTH];
    logic [DATA_WIDTH-1:0] from_next [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_first
            assign from_prev[g] = wr_word;
        end else begin : g_mid_prev
            assign from_prev[g] = entry_reg[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign from_next[g] = entry_reg[g];
        end else begin : g_mid_next
            assign from_next[g] = entry_reg[g+1];
        end
    end

    // entries at or behind idx move one place back on insert, forward on extract
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (ctl.ins) begin
                if (IDX_W'(i) == idx) begin
                    entry_reg[i] <= wr_word;
                end else if (IDX_W'(i) > idx) begin
                    entry_reg[i] <= from_prev[i];
                end
            end else if (ctl.ext) begin
                if (IDX_W'(i) >= idx) begin
                    entry_reg[i] <= from_next[i];
                end
            end
        end
    end

    assign rd_word = entry_reg[idx];

endmodule

`default_nettype wire

// ===== design/bounded_positional_list.sv =====
// Bounded positional list: top level with stream channels and capacity register.
// Depends on bpl_pkg and bpl_store.
//
// Usage:
//   s_ channel carries one request per transaction: the operation in s_tuser,
//   position and value in s_tdata. m_ channel returns exactly one result per
//   request: word, status, count and the empty and full flags in m_tdata.
//   cfg_wr_en writes cfg_wr_data into the capacity register; write it only
//   while no request is in flight.
//   A request accepted on s_ sits in an input register and is executed against
//   the list in the cycle it moves into the result register, all entries
//   shifting in parallel; the result then shows on m_. Throughput: one request
//   per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; s_tready drops only when both
//   are occupied. The list state changes only when a request executes.
//   Reset empties the list (entries are not cleared, they are never read
//   before being written) and sets capacity to 16.
`default_nettype none

module bounded_positional_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config
    input  wire logic                            cfg_wr_en,
    input  wire logic [bpl_pkg::CAP_W-1:0]       cfg_wr_data,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [3:0] position, [35:4] value, [39:36] zero
    input  wire logic [bpl_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] operation
    input  wire logic [bpl_pkg::OP_W-1:0]        s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] result_value, [33:32] status, [38:34] count, [39] is_empty,
    // [40] is_full, [47:41] zero
    output logic [bpl_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LEN_W > bpl_pkg::CAP_W) ? LEN_W : bpl_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    // input register
    logic                           in_valid_reg;
    bpl_pkg::op_t                   op_reg;
    logic [bpl_pkg::POS_W-1:0]      pos_reg;
    logic [bpl_pkg::VALUE_W-1:0]    val_reg;

    // list state and config
    logic [LEN_W-1:0]               len_reg;
    logic [LEN_W-1:0]               len_next;
    logic [bpl_pkg::CAP_W-1:0]      cap_reg;

    // result register
    logic                           out_valid_reg;
    logic [bpl_pkg::VALUE_W-1:0]    res_reg;
    logic [bpl_pkg::VALUE_W-1:0]    res_next;
    bpl_pkg::status_t               status_reg;
    bpl_pkg::status_t               status_next;
    logic [bpl_pkg::COUNT_W-1:0]    count_reg;
    logic                           empty_reg;
    logic                           full_reg;
    logic                           full_next;

    logic                           advance;
    logic                           full_now;
    logic [CMP_W-1:0]               len_w;
    logic [CMP_W-1:0]               cap_w;
    logic [CMP_W-1:0]               pos_w;
    logic [CMP_W-1:0]               pick_w;
    logic [CMP_W-1:0]               idx_w;
    bpl_pkg::store_ctl_t            ctl;
    logic [DATA_WIDTH-1:0]          rd_word;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= bpl_pkg::op_t'(s_tuser);
            pos_reg <= s_tdata[bpl_pkg::POS_W-1:0];
            val_reg <= s_tdata[bpl_pkg::POS_W +: bpl_pkg::VALUE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bpl_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign len_w    = CMP_W'(len_reg);
    assign cap_w    = CMP_W'(cap_reg);
    assign pos_w    = CMP_W'(pos_reg);
    // capacity above storage acts as the storage depth
    assign full_now = (len_w >= cap_w) || (len_w >= DEPTH_C);

    always_comb begin
        ctl         = '0;
        idx_w       = '0;
        pick_w      = '0;
        len_next    = len_reg;
        status_next = bpl_pkg::ST_OK;
        res_next    = '0;
        unique case (op_reg) inside
            bpl_pkg::OP_INS_FIRST, bpl_pkg::OP_INS_LAST, bpl_pkg::OP_INS_AT: begin
                if (full_now) begin
                    status_next = bpl_pkg::ST_FULL;
                end else begin
                    ctl.ins  = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                    if (op_reg == bpl_pkg::OP_INS_FIRST) begin
                        idx_w = '0;
                    end else if (op_reg == bpl_pkg::OP_INS_LAST || pos_w >= len_w) begin
                        idx_w = len_w;
                    end else begin
                        idx_w = pos_w;
                    end
                end
            end
            bpl_pkg::OP_EXT_FIRST, bpl_pkg::OP_EXT_LAST, bpl_pkg::OP_EXT_AT,
            bpl_pkg::OP_READ_AT: begin
                if (op_reg == bpl_pkg::OP_EXT_FIRST) begin
                    pick_w = '0;
                end else if (op_reg == bpl_pkg::OP_EXT_LAST) begin
                    pick_w = len_w - CMP_W'(1);
                end else begin
                    pick_w = pos_w;
                end
                // empty list fails here too: every pick is at or past zero
                if (pick_w >= len_w) begin
                    status_next = bpl_pkg::ST_RANGE;
                end else begin
                    idx_w    = pick_w;
                    res_next = bpl_pkg::VALUE_W'(rd_word);
                    if (op_reg != bpl_pkg::OP_READ_AT) begin
                        ctl.ext  = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                    end
                end
            end
            bpl_pkg::OP_CLEAR: begin
                len_next = '0;
            end
            default: begin
                len_next = len_reg;
            end
        endcase
        full_next = (CMP_W'(len_next) >= cap_w) || (CMP_W'(len_next) >= DEPTH_C);
    end

    bpl_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .ctl     (advance ? ctl : '0),
        .idx     (idx_w[IDX_W-1:0]),
        .wr_word (DATA_WIDTH'(val_reg)),
        .rd_word (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg    <= res_next;
            status_reg <= status_next;
            count_reg  <= bpl_pkg::COUNT_W'(len_next);
            empty_reg  <= (len_next == '0);
            full_reg   <= full_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bpl_pkg::M_TDATA_W'({full_reg, empty_reg, count_reg, status_reg, res_reg});

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(DEPTH))
        else $error("list length beyond storage depth");

    a_refused_keeps_len: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && status_next == bpl_pkg::ST_FULL |=> $stable(len_reg))
        else $error("refused insert changed the length");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctl.ins |=> len_reg == $past(len_reg) + LEN_W'(1))
        else $error("insert did not grow the list by one");

    a_ready_only_when_both_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_count_matches_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> count_reg == bpl_pkg::COUNT_W'(len_reg))
        else $error("reported count differs from list length");

endmodule

`default_nettype wire
